FILE: rtl/core/prf_pkg.sv
// ----------------------------------------------------------------------------
// prf_pkg: shared constants, types and helpers of the pair restraint force
// Widths of the datapath, register codes and the saturating output encoder.
// ----------------------------------------------------------------------------
package prf_pkg;

  localparam int DATA_W        = 32;  // width of every coordinate and result
  localparam int TGT_W         = 31;  // width of the target distance register
  localparam int MAG_W         = 32;  // magnitude of one coordinate difference
  localparam int SQ_W          = 2 * MAG_W;
  localparam int RAD_W         = SQ_W + 2;  // sum of three squares
  localparam int ROOT_W        = 33;  // floor square root of RAD_W bits
  localparam int QUO_W         = 32;  // quotient bits kept before saturation
  localparam int DEF_FRAC_BITS = 16;

  localparam logic [TGT_W-1:0] TGT_RESET = TGT_W'(65536);

  typedef enum logic [0:0] {
    CFG_BIAS   = 1'b0,
    CFG_TARGET = 1'b1
  } cfg_idx_e;

  // Magnitudes and signs of the three coordinate differences.
  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } diff_t;

  // Signed result from a quotient magnitude, saturated to the field range.
  function automatic logic [DATA_W-1:0] sat_word(input logic [QUO_W-1:0] q,
                                                 input logic ovf,
                                                 input logic neg);
    logic [QUO_W:0] cap;
    logic [QUO_W:0] m;
    logic [QUO_W:0] r;
    cap = neg ? {2'b01, {(QUO_W-1){1'b0}}} : {2'b00, {(QUO_W-1){1'b1}}};
    m   = (ovf || ({1'b0, q} > cap)) ? cap : {1'b0, q};
    r   = neg ? (~m + 1'b1) : m;
    return r[DATA_W-1:0];
  endfunction

endpackage

FILE: rtl/core/prf_front.sv
// ----------------------------------------------------------------------------
// prf_front: coordinate differences and squared distance
// Three stages: differences and magnitudes, squares, sum of squares.
// ----------------------------------------------------------------------------
module prf_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [2:0][prf_pkg::DATA_W-1:0]       first_i,
  input  logic [2:0][prf_pkg::DATA_W-1:0]       second_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [prf_pkg::RAD_W-1:0]             rad_o,
  output prf_pkg::diff_t                        diff_o
);
  import prf_pkg::*;

  logic  va_q, vb_q, vc_q;
  logic  en_a, en_b, en_c;
  diff_t diff_d, diffa_q, diffb_q, diffc_q;
  logic [2:0][SQ_W-1:0] sq_q;
  logic [RAD_W-1:0]     rad_q;

  assign en_c       = !vc_q || out_ready_i;
  assign en_b       = !vb_q || en_c;
  assign en_a       = !va_q || en_b;
  assign in_ready_o = en_a;

  always_comb begin
    logic [DATA_W:0] d;
    logic [DATA_W:0] dn;
    for (int i = 0; i < 3; i++) begin
      d              = {first_i[i][DATA_W-1], first_i[i]} -
                       {second_i[i][DATA_W-1], second_i[i]};
      dn             = ~d + 1'b1;
      diff_d.neg[i]  = d[DATA_W];
      diff_d.mag[i]  = d[DATA_W] ? dn[MAG_W-1:0] : d[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (en_a) va_q <= in_valid_i;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      diffa_q <= diff_d;
    end
    if (en_b) begin
      diffb_q <= diffa_q;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= SQ_W'(diffa_q.mag[i]) * SQ_W'(diffa_q.mag[i]);
      end
    end
    if (en_c) begin
      diffc_q <= diffb_q;
      rad_q   <= RAD_W'(sq_q[0]) + RAD_W'(sq_q[1]) + RAD_W'(sq_q[2]);
    end
  end

  assign out_valid_o = vc_q;
  assign rad_o       = rad_q;
  assign diff_o      = diffc_q;

endmodule

FILE: rtl/core/prf_isqrt.sv
// ----------------------------------------------------------------------------
// prf_isqrt: pipelined integer square root
// One root bit per stage, digit by digit on the running remainder.
// ----------------------------------------------------------------------------
module prf_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [prf_pkg::RAD_W-1:0]     rad_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [prf_pkg::ROOT_W-1:0]    root_o,
  output logic [SIDE_W-1:0]             side_o
);
  import prf_pkg::*;

  logic                v_q    [ROOT_W];
  logic [RAD_W-1:0]    rem_q  [ROOT_W];
  logic [ROOT_W-1:0]   root_q [ROOT_W];
  logic [SIDE_W-1:0]   side_q [ROOT_W];
  logic [ROOT_W:0]     en;

  // A stage moves on when it is empty or its successor moves on.
  always_comb begin
    en[ROOT_W] = out_ready_i;
    for (int k = ROOT_W - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic              pv;
    logic [RAD_W-1:0]  prem;
    logic [ROOT_W-1:0] proot;
    logic [SIDE_W-1:0] pside;
    logic [RAD_W:0]    trial;
    logic              take;

    if (k == 0) begin : g_first
      assign pv    = in_valid_i;
      assign prem  = rad_i;
      assign proot = '0;
      assign pside = side_i;
    end else begin : g_next
      assign pv    = v_q[k-1];
      assign prem  = rem_q[k-1];
      assign proot = root_q[k-1];
      assign pside = side_q[k-1];
    end

    // (2r + 2^b) * 2^b, with r holding only bits above b.
    assign trial = ((RAD_W+1)'(proot) << (B + 1)) | ((RAD_W+1)'(1) << (2 * B));
    assign take  = {1'b0, prem} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        rem_q[k]  <= take ? (prem - trial[RAD_W-1:0]) : prem;
        root_q[k] <= take ? (proot | (ROOT_W'(1) << B)) : proot;
        side_q[k] <= pside;
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[ROOT_W-1];
  assign root_o      = root_q[ROOT_W-1];
  assign side_o      = side_q[ROOT_W-1];

endmodule

FILE: rtl/core/prf_div.sv
// ----------------------------------------------------------------------------
// prf_div: pipelined restoring divider with overflow flag
// An overflow check on the upper numerator, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module prf_div #(
  parameter int NUM_W  = 65,
  parameter int DEN_W  = 31,
  parameter int SIDE_W = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [NUM_W-1:0]              num_i,
  input  logic [DEN_W-1:0]              den_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [prf_pkg::QUO_W-1:0]     quo_o,
  output logic                          ovf_o,
  output logic [SIDE_W-1:0]             side_o
);
  import prf_pkg::*;

  localparam int HI_W  = NUM_W - QUO_W;
  localparam int CMP_W = ((HI_W > DEN_W) ? HI_W : DEN_W) + 1;
  localparam int NSTG  = QUO_W + 1;

  logic              v_q    [NSTG];
  logic [DEN_W-1:0]  rem_q  [NSTG];
  logic [DEN_W-1:0]  den_q  [NSTG];
  logic [QUO_W-1:0]  lo_q   [NSTG];
  logic [QUO_W-1:0]  quo_q  [NSTG];
  logic              ovf_q  [NSTG];
  logic [SIDE_W-1:0] side_q [NSTG];
  logic [NSTG:0]     en;

  always_comb begin
    en[NSTG] = out_ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    logic              pv;
    logic [DEN_W-1:0]  nrem;
    logic [DEN_W-1:0]  pden;
    logic [QUO_W-1:0]  nlo;
    logic [QUO_W-1:0]  nquo;
    logic              novf;
    logic [SIDE_W-1:0] pside;

    if (k == 0) begin : g_first
      logic [CMP_W-1:0] hi;
      assign hi    = CMP_W'(num_i[NUM_W-1:QUO_W]);
      // A quotient of 2^32 or more saturates whatever the sign.
      assign novf  = hi >= CMP_W'(den_i);
      assign nrem  = novf ? '0 : hi[DEN_W-1:0];
      assign pv    = in_valid_i;
      assign pden  = den_i;
      assign nlo   = num_i[QUO_W-1:0];
      assign nquo  = '0;
      assign pside = side_i;
    end else begin : g_next
      logic [DEN_W:0] trial;
      logic           take;
      assign pv    = v_q[k-1];
      assign pden  = den_q[k-1];
      assign pside = side_q[k-1];
      assign novf  = ovf_q[k-1];
      assign trial = {rem_q[k-1], lo_q[k-1][QUO_W-1]};
      assign take  = trial >= {1'b0, pden};
      assign nrem  = take ? DEN_W'(trial - {1'b0, pden}) : trial[DEN_W-1:0];
      assign nlo   = lo_q[k-1] << 1;
      assign nquo  = {quo_q[k-1][QUO_W-2:0], take};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        rem_q[k]  <= nrem;
        den_q[k]  <= pden;
        lo_q[k]   <= nlo;
        quo_q[k]  <= nquo;
        ovf_q[k]  <= novf;
        side_q[k] <= pside;
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NSTG-1];
  assign quo_o       = quo_q[NSTG-1];
  assign ovf_o       = ovf_q[NSTG-1];
  assign side_o      = side_q[NSTG-1];

endmodule

FILE: rtl/core/pair_restraint_force.sv
// ----------------------------------------------------------------------------
// pair_restraint_force: linear bias pair restraint, energy and force
// Distance of two sites, energy alpha*R/target and force alpha*d/(target*R).
// ----------------------------------------------------------------------------
//   port group   dir  handshake              word
//   in           in   in_valid_i/in_ready_o   first_*, second_* (Q16.16)
//   out          out  out_valid_o/out_ready_i energy, force_* (Q16.16)
//   cfg          in   cfg_we_i                cfg_idx_i, cfg_data_i
//
// One word is taken per cycle while the output is not held; each result passes three
// front stages, 33 square root stages, one multiply stage, 33 divider stages
// and the output register. The root and the dividers set that depth.
// Reset empties the pipeline and loads the registers with their reset values.
// Every stage holds while it is full and its successor holds, so a stall at the output
// fills the bubbles first and then stops the input; nothing is dropped.
// ----------------------------------------------------------------------------
module pair_restraint_force #(
  parameter int FRAC_BITS = prf_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  prf_pkg::cfg_idx_e             cfg_idx_i,
  input  logic [prf_pkg::DATA_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [prf_pkg::DATA_W-1:0]    first_x_i,
  input  logic [prf_pkg::DATA_W-1:0]    first_y_i,
  input  logic [prf_pkg::DATA_W-1:0]    first_z_i,
  input  logic [prf_pkg::DATA_W-1:0]    second_x_i,
  input  logic [prf_pkg::DATA_W-1:0]    second_y_i,
  input  logic [prf_pkg::DATA_W-1:0]    second_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [prf_pkg::DATA_W-1:0]    energy_o,
  output logic [prf_pkg::DATA_W-1:0]    force_x_o,
  output logic [prf_pkg::DATA_W-1:0]    force_y_o,
  output logic [prf_pkg::DATA_W-1:0]    force_z_o
);
  import prf_pkg::*;

  localparam int EN_W = MAG_W + ROOT_W;
  localparam int FN_W = SQ_W + FRAC_BITS;
  localparam int FD_W = TGT_W + ROOT_W;

  logic [DATA_W-1:0] alpha_q;
  logic [TGT_W-1:0]  target_q;
  logic [TGT_W-1:0]  tgt;
  logic [MAG_W-1:0]  amag;
  logic              aneg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= '0;
      target_q <= TGT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BIAS:   alpha_q  <= cfg_data_i;
        CFG_TARGET: target_q <= cfg_data_i[TGT_W-1:0];
        default:    ;
      endcase
    end
  end

  // A zero target acts as the smallest step.
  assign tgt  = (target_q == '0) ? TGT_W'(1) : target_q;
  assign aneg = alpha_q[DATA_W-1];
  assign amag = aneg ? (~alpha_q + 1'b1) : alpha_q;

  // Front and square root.
  logic             fr_valid, fr_ready;
  logic [RAD_W-1:0] fr_rad;
  diff_t            fr_diff;
  logic             sq_valid, sq_ready;
  logic [ROOT_W-1:0] sq_root;
  logic [$bits(diff_t)-1:0] sq_side;
  diff_t            sq_diff;

  prf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .first_i     ({first_z_i, first_y_i, first_x_i}),
    .second_i    ({second_z_i, second_y_i, second_x_i}),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .rad_o       (fr_rad),
    .diff_o      (fr_diff)
  );

  prf_isqrt #(
    .SIDE_W ($bits(diff_t))
  ) u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .rad_i       (fr_rad),
    .side_i      (fr_diff),
    .out_valid_o (sq_valid),
    .out_ready_i (sq_ready),
    .root_o      (sq_root),
    .side_o      (sq_side)
  );

  assign sq_diff = diff_t'(sq_side);

  // Multiply stage: numerators, divisors, sign flags and the zero-force flag.
  logic                  vm_q, en_m;
  logic [EN_W-1:0]       enum_q;
  logic [2:0][FN_W-1:0]  fnum_q;
  logic [FD_W-1:0]       fden_q;
  logic [TGT_W-1:0]      eden_q;
  logic                  eneg_q;
  logic                  fzero_q;
  logic [2:0]            fneg_q;
  logic                  div_ready, dx_in_rdy, dy_in_rdy, dz_in_rdy;
  logic                  beyond;

  assign en_m     = !vm_q || div_ready;
  assign sq_ready = en_m;
  assign beyond   = sq_root > ROOT_W'(tgt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en_m) begin
      vm_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_m) begin
      enum_q  <= EN_W'(amag) * EN_W'(sq_root);
      fden_q  <= FD_W'(tgt) * FD_W'(sq_root);
      eden_q  <= tgt;
      eneg_q  <= aneg;
      fzero_q <= (sq_root == '0) || (sq_root == ROOT_W'(tgt));
      for (int i = 0; i < 3; i++) begin
        fnum_q[i] <= {SQ_W'(amag) * SQ_W'(sq_diff.mag[i]), {FRAC_BITS{1'b0}}};
        fneg_q[i] <= aneg ^ sq_diff.neg[i] ^ beyond;
      end
    end
  end

  // Dividers run in lockstep: same valid in, same ready out.
  logic                de_valid, dx_valid, dy_valid, dz_valid;
  logic [QUO_W-1:0]    e_quo, x_quo, y_quo, z_quo;
  logic                e_ovf, x_ovf, y_ovf, z_ovf;
  logic                e_neg;
  logic [1:0]          x_side, y_side, z_side;
  logic                vo_q, en_o;

  assign en_o = !vo_q || out_ready_i;

  prf_div #(.NUM_W(EN_W), .DEN_W(TGT_W), .SIDE_W(1)) u_div_e (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .in_valid_i (vm_q), .in_ready_o (div_ready),
    .num_i (enum_q), .den_i (eden_q), .side_i (eneg_q),
    .out_valid_o (de_valid), .out_ready_i (en_o),
    .quo_o (e_quo), .ovf_o (e_ovf), .side_o (e_neg)
  );

  prf_div #(.NUM_W(FN_W), .DEN_W(FD_W), .SIDE_W(2)) u_div_x (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .in_valid_i (vm_q), .in_ready_o (dx_in_rdy),
    .num_i (fnum_q[0]), .den_i (fden_q), .side_i ({fzero_q, fneg_q[0]}),
    .out_valid_o (dx_valid), .out_ready_i (en_o),
    .quo_o (x_quo), .ovf_o (x_ovf), .side_o (x_side)
  );

  prf_div #(.NUM_W(FN_W), .DEN_W(FD_W), .SIDE_W(2)) u_div_y (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .in_valid_i (vm_q), .in_ready_o (dy_in_rdy),
    .num_i (fnum_q[1]), .den_i (fden_q), .side_i ({fzero_q, fneg_q[1]}),
    .out_valid_o (dy_valid), .out_ready_i (en_o),
    .quo_o (y_quo), .ovf_o (y_ovf), .side_o (y_side)
  );

  prf_div #(.NUM_W(FN_W), .DEN_W(FD_W), .SIDE_W(2)) u_div_z (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .in_valid_i (vm_q), .in_ready_o (dz_in_rdy),
    .num_i (fnum_q[2]), .den_i (fden_q), .side_i ({fzero_q, fneg_q[2]}),
    .out_valid_o (dz_valid), .out_ready_i (en_o),
    .quo_o (z_quo), .ovf_o (z_ovf), .side_o (z_side)
  );

  // Output register with saturation.
  logic [DATA_W-1:0] energy_q, fx_q, fy_q, fz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_o) begin
      vo_q <= de_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      energy_q <= sat_word(e_quo, e_ovf, e_neg);
      fx_q     <= x_side[1] ? '0 : sat_word(x_quo, x_ovf, x_side[0]);
      fy_q     <= y_side[1] ? '0 : sat_word(y_quo, y_ovf, y_side[0]);
      fz_q     <= z_side[1] ? '0 : sat_word(z_quo, z_ovf, z_side[0]);
    end
  end

  assign out_valid_o = vo_q;
  assign energy_o    = energy_q;
  assign force_x_o   = fx_q;
  assign force_y_o   = fy_q;
  assign force_z_o   = fz_q;

  // The four dividers must never drift apart.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (de_valid == dx_valid) && (dx_valid == dy_valid) && (dy_valid == dz_valid) &&
    (div_ready == dx_in_rdy) && (dx_in_rdy == dy_in_rdy) && (dy_in_rdy == dz_in_rdy))
    else $error("divider lanes out of step");

  // The input only stalls once the whole pipeline is full behind a held word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && vm_q))
    else $error("input stalled with room in the pipeline");

  // A word in the multiply stage that the divider cannot take must stay there.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vm_q && !div_ready) |=> vm_q)
    else $error("multiply stage lost a word");

endmodule
